FILE: rtl/otis_pkg.sv
// Shared types and constants for the offset table interval search block.
`default_nettype none

package otis_pkg;

  // Fixed field widths of the request channels and the register file.
  localparam int IDX_W   = 10;
  localparam int OFS_W   = 32;
  localparam int COUNT_W = 11;
  localparam int TOTAL_W = 33;
  localparam int APB_DW  = 64;
  localparam int APB_AW  = 4;

  // Function codes carried by an input request.
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Register select, taken from address bit 3 (registers sit 8 bytes apart).
  localparam logic REG_SEQ_COUNT = 1'b0;
  localparam logic REG_TOTAL_LEN = 1'b1;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] entry_index;
    logic [OFS_W-1:0] entry_offset;
    logic [OFS_W-1:0] position;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] sequence_index;
    logic             out_of_range;
  } out_req_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic load_entry;
    logic issue;
    logic compare;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/offset_table_interval_search.sv
// Top level of the offset table interval search block.
`default_nettype none

// Holds a table of sequence start offsets written by load requests and finds
// the sequence that holds a position by bisection. Load requests do not stall
// the input. A lookup runs k bisection steps between acceptance and the next
// acceptance, one per dual-port table read, at most about log2 of the entry
// count plus one (11 for 1024 entries). A position at or above total_length
// is answered with out_of_range set and index 0. The result sits in an output
// register, so the next request is taken while a result waits to be drained.
// Registers: sequence_count at byte address 0, total_length at byte address 8.
module offset_table_interval_search #(
  parameter int MAX_SEQUENCES = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire otis_pkg::in_req_t             in_req,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output otis_pkg::out_req_t                 out_req,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [otis_pkg::APB_AW-1:0]   paddr,
  input  wire logic [otis_pkg::APB_DW-1:0]   pwdata,
  output logic      [otis_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);

  import otis_pkg::*;

  logic [COUNT_W-1:0] count_r;
  logic [TOTAL_W-1:0] total_r;
  logic               cfg_wr;
  ctrl_cmd_t          cmd;
  dp_sts_t            sts;

  // Register file write and read.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        REG_SEQ_COUNT: count_r <= pwdata[COUNT_W-1:0];
        REG_TOTAL_LEN: total_r <= pwdata[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_SEQ_COUNT: prdata = APB_DW'(count_r);
      REG_TOTAL_LEN: prdata = APB_DW'(total_r);
      default:       prdata = '0;
    endcase
  end

  otis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_req.func),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  otis_dp #(
    .MAX_SEQUENCES (MAX_SEQUENCES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_req    (in_req),
    .cfg_count (count_r),
    .cfg_total (total_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

`ifndef SYNTH
  // An accepted lookup keeps the input side busy in the following cycle.
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_req.func == FUNC_LOOKUP) |=> in_stall)
    else $error("input not stalled after a lookup request");

  // A result only appears after the controller loads the output register.
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("result appeared without an output load");

  // An out-of-range answer always carries index zero.
  a_oor_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_req.out_of_range) |-> (out_req.sequence_index == '0))
    else $error("out-of-range result with nonzero index");

  // A count write lands in the register on the next cycle.
  a_count_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && paddr[3] == REG_SEQ_COUNT) |=> (count_r == $past(pwdata[COUNT_W-1:0])))
    else $error("sequence count write lost");
`endif

endmodule

`default_nettype wire

FILE: rtl/otis_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module otis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Both read ports are registered: data returns in the cycle after the address.
  always_ff @(posedge clk) begin
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

`default_nettype wire

FILE: rtl/otis_ctrl.sv
// Controller state machine that sequences loads and bisection lookups.
`default_nettype none

module otis_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_func,
  input  wire otis_pkg::dp_sts_t    sts,
  output otis_pkg::ctrl_cmd_t       cmd,
  output logic                      in_stall
);

  import otis_pkg::*;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_ISSUE   = 2'd1;
  localparam logic [1:0] ST_COMPARE = 2'd2;
  localparam logic [1:0] ST_FINISH  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_func == FUNC_LOOKUP) begin
            cmd.start = 1'b1;
            state_nxt = ST_ISSUE;
          end else begin
            cmd.load_entry = 1'b1;
          end
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        state_nxt = sts.go ? ST_COMPARE : ST_FINISH;
      end
      ST_COMPARE: begin
        cmd.compare = 1'b1;
        state_nxt   = sts.go ? ST_COMPARE : ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/otis_dp.sv
// Datapath: offset table, bisection bounds and the output register.
`default_nettype none

module otis_dp #(
  parameter int MAX_SEQUENCES = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire otis_pkg::ctrl_cmd_t            cmd,
  output otis_pkg::dp_sts_t                   sts,
  input  wire otis_pkg::in_req_t              in_req,
  input  wire logic [otis_pkg::COUNT_W-1:0]   cfg_count,
  input  wire logic [otis_pkg::TOTAL_W-1:0]   cfg_total,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output otis_pkg::out_req_t                  out_req
);

  import otis_pkg::*;

  localparam int AW    = $clog2(MAX_SEQUENCES);
  localparam int CNT_W = $clog2(MAX_SEQUENCES + 1);

  logic [OFS_W-1:0] pos_r;
  logic             oor_r;
  logic [CNT_W-1:0] lo_r;
  logic [CNT_W-1:0] hi_r;
  logic [AW-1:0]    mid_r;
  logic             out_valid_r;
  out_req_t         out_req_r;

  logic [CNT_W-1:0] n_c;
  logic [OFS_W-1:0] rd_mid;
  logic [OFS_W-1:0] rd_next;
  logic [CNT_W-1:0] mid_ext;
  logic [CNT_W-1:0] mid_inc;
  logic             stop_c;
  logic [CNT_W-1:0] lo_upd;
  logic [CNT_W-1:0] hi_upd;
  logic [CNT_W-1:0] lo_c;
  logic [CNT_W-1:0] hi_c;
  logic [CNT_W:0]   sum_c;
  logic [AW-1:0]    mid_c;
  logic [AW-1:0]    raddr_next;
  logic             we;

  // Entry count limited to the table depth.
  always_comb begin
    if (32'(cfg_count) > 32'(MAX_SEQUENCES)) begin
      n_c = CNT_W'(MAX_SEQUENCES);
    end else begin
      n_c = CNT_W'(cfg_count);
    end
  end

  // Load requests write the table; indexes past the table are dropped.
  assign we = cmd.load_entry && (32'(in_req.entry_index) < 32'(MAX_SEQUENCES));

  otis_ram #(
    .WIDTH (OFS_W),
    .DEPTH (MAX_SEQUENCES)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (AW'(in_req.entry_index)),
    .wdata   (in_req.entry_offset),
    .raddr_a (mid_c),
    .raddr_b (raddr_next),
    .rdata_a (rd_mid),
    .rdata_b (rd_next)
  );

  // One bisection step against the entries at mid and mid + 1.
  always_comb begin
    mid_ext = CNT_W'(mid_r);
    mid_inc = mid_ext + CNT_W'(1);
    lo_upd  = lo_r;
    hi_upd  = hi_r;
    stop_c  = 1'b0;
    if (pos_r >= rd_mid) begin
      stop_c = (mid_inc == n_c) || (pos_r < rd_next);
      lo_upd = mid_inc;
    end else begin
      hi_upd = mid_ext;
    end
  end

  // Bounds for the next read: updated ones while comparing, held ones at issue.
  always_comb begin
    lo_c         = cmd.compare ? lo_upd : lo_r;
    hi_c         = cmd.compare ? hi_upd : hi_r;
    sum_c        = {1'b0, lo_c} + {1'b0, hi_c};
    mid_c        = AW'(sum_c >> 1);
    raddr_next   = mid_c + AW'(1);
    sts.go       = (lo_c < hi_c) && (cmd.compare ? !stop_c : !oor_r);
    sts.out_free = !out_valid_r || !out_stall;
  end

  // Search registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pos_r <= in_req.position;
      oor_r <= ({1'b0, in_req.position} >= cfg_total);
      lo_r  <= '0;
      hi_r  <= n_c;
      mid_r <= '0;
    end else if ((cmd.issue || cmd.compare) && sts.go) begin
      lo_r  <= lo_c;
      hi_r  <= hi_c;
      mid_r <= mid_c;
    end
  end

  // Output register; a new result may replace one being taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_req_r.sequence_index <= oor_r ? '0 : IDX_W'(mid_r);
      out_req_r.out_of_range   <= oor_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the offset table interval search block.
`default_nettype none

module testbench;
  import otis_pkg::*;

  localparam int MAX_SEQ      = 1024;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE       = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 12;
  localparam int LOOKUPS_EACH = 16;
  localparam logic [APB_AW-1:0] ADDR_SEQ_COUNT = {REG_SEQ_COUNT, 3'b000};
  localparam logic [APB_AW-1:0] ADDR_TOTAL_LEN = {REG_TOTAL_LEN, 3'b000};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_req_t out_req;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  offset_table_interval_search u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_req  (out_req),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor state: table contents and register values as the block sees them.
  logic [31:0] model_starts [MAX_SEQ];
  logic [COUNT_W-1:0] seq_count_q = '0;
  logic [TOTAL_W-1:0] total_len_q = '0;

  // Table contents as planned by the stimulus, used to aim positions.
  logic [31:0] plan_starts [MAX_SEQ];

  in_req_t requests_to_send [$];
  out_req_t pending_answers [$];

  int unsigned items_offered = 0;
  int unsigned items_accepted = 0;
  int unsigned loads_seen = 0;
  int unsigned lookups_seen = 0;
  int unsigned beyond_total = 0;
  int unsigned answers_checked = 0;
  int unsigned settings_written = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_used = 1'b0;
  int unsigned hold_left = 0;

  out_req_t seen_want;

  always #4 clk = ~clk;

  // Bisection over the predicted table, mirroring the block's search.
  function automatic out_req_t locate_sequence(input logic [31:0] pos);
    logic [11:0] n;
    logic [11:0] lo;
    logic [11:0] hi;
    logic [11:0] mid;
    logic found;
    out_req_t ans;
    ans = '0;
    if ({1'b0, pos} >= total_len_q) begin
      ans.out_of_range = 1'b1;
    end else begin
      n = (seq_count_q > MAX_SEQ) ? 12'(MAX_SEQ) : {1'b0, seq_count_q};
      lo = '0;
      hi = n;
      mid = '0;
      found = 1'b0;
      while (!found && lo < hi) begin
        mid = (lo + hi) >> 1;
        if (pos >= model_starts[mid[9:0]]) begin
          if (mid + 12'd1 == n || pos < model_starts[mid[9:0] + 10'd1]) begin
            found = 1'b1;
          end else begin
            lo = mid + 12'd1;
          end
        end else begin
          hi = mid;
        end
      end
      ans.sequence_index = mid[9:0];
    end
    return ans;
  endfunction

  // Random position: mostly near table boundaries, the total length or the extremes.
  function automatic logic [31:0] pick_position(input int unsigned n_eff);
    logic [31:0] pos;
    int unsigned j;
    pos = $urandom;
    case ($urandom_range(9))
      4, 5, 6: begin
        if (n_eff > 0) begin
          j = $urandom_range(n_eff - 1);
          pos = plan_starts[j] + $urandom_range(2) - 1;
        end
      end
      7: pos = total_len_q[31:0] - $urandom_range(1);
      8: pos = $urandom_range(15);
      9: pos = 32'hFFFF_FFFF - $urandom_range(3);
      default: pos = $urandom;
    endcase
    return pos;
  endfunction

  // Total length relative to the last table offset, random, or at the register's extremes.
  function automatic logic [TOTAL_W-1:0] pick_total(input logic [31:0] last);
    logic [TOTAL_W-1:0] t;
    logic [TOTAL_W-1:0] span;
    span = '0;
    case ($urandom_range(5))
      0: t = 33'h1_FFFF_FFFF;
      1: t = 33'h1_0000_0000;
      2: begin
        span[31:0] = $urandom_range(1000);
        t = {1'b0, last} + span;
      end
      3: begin
        span[31:0] = $urandom;
        t = {1'b0, last} + span;
      end
      4: begin
        t[31:0] = $urandom;
        t[32] = 1'($urandom_range(1));
      end
      default: t = '0;
    endcase
    return t;
  endfunction

  // Ascending offsets, usually from zero, with some zero-length sequences.
  task automatic plan_sorted(input int unsigned n);
    int unsigned gap_max;
    int unsigned i;
    logic [31:0] acc;
    gap_max = 32'hFFFF_FFFF / n;
    if ($urandom_range(1) == 1) begin
      gap_max = gap_max >> $urandom_range(24);
    end
    acc = ($urandom_range(9) == 0) ? $urandom_range(gap_max) : 32'd0;
    for (i = 0; i < n; i++) begin
      plan_starts[i] = acc;
      acc = acc + (($urandom_range(7) == 0) ? 32'd0 : $urandom_range(gap_max));
    end
  endtask

  task automatic queue_load(input logic [IDX_W-1:0] idx, input logic [31:0] ofs);
    in_req_t r;
    r.func = FUNC_LOAD;
    r.entry_index = idx;
    r.entry_offset = ofs;
    r.position = $urandom;
    plan_starts[idx] = ofs;
    requests_to_send.push_back(r);
  endtask

  task automatic queue_lookup(input logic [31:0] pos);
    in_req_t r;
    r.func = FUNC_LOOKUP;
    r.entry_index = IDX_W'($urandom_range(MAX_SEQ - 1));
    r.entry_offset = $urandom;
    r.position = pos;
    requests_to_send.push_back(r);
  endtask

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_limits(input logic [COUNT_W-1:0] count, input logic [TOTAL_W-1:0] total);
    write_reg(ADDR_SEQ_COUNT, APB_DW'(count));
    seq_count_q = count;
    write_reg(ADDR_TOTAL_LEN, APB_DW'(total));
    total_len_q = total;
    settings_written++;
  endtask

  // Wait until every request is taken and answered, then let the block settle.
  task automatic wait_idle();
    @(posedge clk);
    while (requests_to_send.size() != 0 || in_valid || pending_answers.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // Run watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Request driver: offers the next queued request once the current one is taken.
  always @(negedge clk) begin
    if (rst_n && items_offered == items_accepted) begin
      if (requests_to_send.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
        in_req <= requests_to_send.pop_front();
        in_valid <= 1'b1;
        items_offered++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side stall: random, one long hold-off on request, none while calm.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 31);
    end
  end

  // Accepted requests update the predicted table or queue the predicted answer.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      items_accepted++;
      if (in_req.func == FUNC_LOAD) begin
        model_starts[in_req.entry_index] = in_req.entry_offset;
        loads_seen++;
      end else begin
        pending_answers.push_back(locate_sequence(in_req.position));
        lookups_seen++;
        if ({1'b0, in_req.position} >= total_len_q) beyond_total++;
      end
    end
  end

  // Result monitor: compare each delivered result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: sequence_index %0d out_of_range %0b",
               out_req.sequence_index, out_req.out_of_range);
        err_count++;
      end else begin
        seen_want = pending_answers.pop_front();
        answers_checked++;
        if (out_req.sequence_index !== seen_want.sequence_index) begin
          $error("sequence_index: expected %0d, actual %0d",
                 seen_want.sequence_index, out_req.sequence_index);
          err_count++;
        end
        if (out_req.out_of_range !== seen_want.out_of_range) begin
          $error("out_of_range: expected %0b, actual %0b",
                 seen_want.out_of_range, out_req.out_of_range);
          err_count++;
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    int unsigned phase;
    int unsigned count_sel;
    int unsigned n_eff;
    int unsigned i;
    int unsigned r;
    logic [31:0] last;
    logic [TOTAL_W-1:0] total;
    logic full_written;

    full_written = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: nothing is below a zero total length.
    queue_lookup(32'd0);
    queue_lookup(32'hFFFF_FFFF);
    wait_idle();

    // Empty table with the largest total length: the search does not run.
    set_limits(COUNT_W'(0), 33'h1_FFFF_FFFF);
    queue_lookup(32'd0);
    queue_lookup(32'hFFFF_FFFF);
    wait_idle();

    // Single entry.
    set_limits(COUNT_W'(1), 33'h1_0000_0000);
    queue_load(IDX_W'(0), 32'd0);
    queue_lookup(32'd0);
    queue_lookup(32'hFFFF_FFFF);
    wait_idle();

    // Small table with a zero-length sequence, the top entry index, and the total bound.
    set_limits(COUNT_W'(5), 33'd100);
    queue_load(IDX_W'(0), 32'd0);
    queue_load(IDX_W'(1), 32'd10);
    queue_load(IDX_W'(2), 32'd10);
    queue_load(IDX_W'(3), 32'd20);
    queue_load(IDX_W'(4), 32'hFFFF_FFFF);
    queue_load(10'd1023, 32'hFFFF_FFFF);
    queue_lookup(32'd0);
    queue_lookup(32'd9);
    queue_lookup(32'd10);
    queue_lookup(32'd19);
    queue_lookup(32'd20);
    queue_lookup(32'd99);
    queue_lookup(32'd100);
    wait_idle();
    set_limits(COUNT_W'(5), 33'h1_FFFF_FFFF);
    queue_lookup(32'hFFFF_FFFF);
    wait_idle();

    // Random phases over several table sizes and total lengths.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        4: count_sel = MAX_SEQ;
        5: count_sel = (1 << COUNT_W) - 1;
        8: count_sel = MAX_SEQ + 1 + $urandom_range(900);
        default: begin
          r = $urandom_range(9);
          if (r < 3) count_sel = r;
          else if (r < 7) count_sel = $urandom_range(16, 3);
          else count_sel = $urandom_range(100, 17);
        end
      endcase
      n_eff = (count_sel > MAX_SEQ) ? MAX_SEQ : count_sel;

      // Counts beyond the table reuse the full table written earlier.
      if (count_sel <= MAX_SEQ && n_eff > 0) begin
        if (phase != 4 && $urandom_range(3) == 0) begin
          for (i = 0; i < n_eff; i++) plan_starts[i] = $urandom;
        end else begin
          plan_sorted(n_eff);
        end
      end
      last = (n_eff > 0) ? plan_starts[n_eff - 1] : 32'd0;
      total = pick_total(last);

      set_limits(count_sel[COUNT_W-1:0], total);
      calm = (phase == 2);
      hold_req = (phase == 7);
      if (count_sel <= MAX_SEQ) begin
        for (i = 0; i < n_eff; i++) queue_load(i[IDX_W-1:0], plan_starts[i]);
        if (n_eff == MAX_SEQ) full_written = 1'b1;
      end
      for (i = 0; i < LOOKUPS_EACH; i++) begin
        queue_lookup(pick_position(n_eff));
        if ($urandom_range(9) == 0) begin
          queue_load(IDX_W'($urandom_range(MAX_SEQ - 1)), $urandom);
        end
      end
      wait_idle();
      calm = 1'b0;
    end

    $display("Covered %0d loads and %0d lookups (%0d beyond the total length)",
             loads_seen, lookups_seen, beyond_total);
    $display("over %0d register settings; %0d results checked, full table used: %0b",
             settings_written, answers_checked, full_written);
    if (err_count == 0 && pending_answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
